// ===== hdl/slcp_pkg.sv =====
// slcp_pkg: shared constants, types and keyword tables for the servo/LED command parser.
// Used by slcp_cmd_word and servo_led_command_parser; depends on nothing.
`timescale 1ns / 1ps

package slcp_pkg;

	// default sizes
	localparam int LED_COUNT_DEF  = 3;
	localparam int WORD_BYTES_DEF = 8;

	// configuration register reset values
	localparam logic [15:0] ZERO_PULSE_RST  = 16'd590;
	localparam logic [11:0] PULSE_SPAN_RST  = 12'd1945;
	localparam logic [15:0] PULSE_LIMIT_RST = 16'd2535;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_ZERO_PULSE  = 2'd0;
	localparam logic [1:0] REG_PULSE_SPAN  = 2'd1;
	localparam logic [1:0] REG_PULSE_LIMIT = 2'd2;

	// executed / command codes
	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_SERVO   = 2'd1;
	localparam logic [1:0] CMD_LED_ON  = 2'd2;
	localparam logic [1:0] CMD_LED_OFF = 2'd3;

	// special bytes
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// keyword tables
	localparam int KW_SERVO_LEN  = 6;
	localparam int KW_LEDON_LEN  = 6;
	localparam int KW_LEDOFF_LEN = 7;
	localparam logic [7:0] KW_SERVO [KW_SERVO_LEN]  = '{8'h73, 8'h65, 8'h72, 8'h76, 8'h6F, 8'h2C};
	localparam logic [7:0] KW_LEDON [KW_LEDON_LEN]  = '{8'h6C, 8'h65, 8'h64, 8'h6F, 8'h6E, 8'h2C};
	localparam logic [7:0] KW_LEDOFF [KW_LEDOFF_LEN] =
		'{8'h6C, 8'h65, 8'h64, 8'h6F, 8'h66, 8'h66, 8'h2C};

	// byte of the word cleared on execute
	localparam int EXEC_CLEAR_BYTE = 6;

	// span * angle fits in 20 bits (4095 * 255); floor(x / 180) = (x * magic) >> 28
	// is exact over that range
	localparam int          PROD_W    = 20;
	localparam int          MAGIC_W   = 21;
	localparam int          DIV_SHIFT = 28;
	localparam int          QUOT_W    = 13;
	localparam logic [20:0] DIV_MAGIC = 21'd1491309;

	typedef struct packed {
		logic store;  // write the byte at the fill position
		logic exec;   // rewind the fill and clear the execute byte
	} word_ctl_t;

endpackage

// ===== hdl/slcp_cmd_word.sv =====
// slcp_cmd_word: command word store, fill counter and keyword match.
// Depends on slcp_pkg.
`timescale 1ns / 1ps

module slcp_cmd_word #(
	parameter int WORD_BYTES = slcp_pkg::WORD_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  slcp_pkg::word_ctl_t       wctl,
	input  logic [7:0]                data,
	output logic [1:0]                cmd
);

	localparam int FILL_W = $clog2(WORD_BYTES + 1);

	logic [7:0]        word_q [WORD_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic              room;
	logic              servo_hit;
	logic              ledon_hit;
	logic              ledoff_hit;

	assign room = fill_q < FILL_W'(WORD_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < WORD_BYTES; i++) begin
				word_q[i] <= '0;
			end
		end else if (wctl.exec) begin
			fill_q                  <= '0;
			word_q[slcp_pkg::EXEC_CLEAR_BYTE] <= '0;
		end else if (wctl.store && room) begin
			fill_q <= fill_q + FILL_W'(1);
			for (int i = 0; i < WORD_BYTES; i++) begin
				if (fill_q == FILL_W'(i)) begin
					word_q[i] <= data;
				end
			end
		end
	end

	// exact string match: keyword bytes, then a terminating zero byte
	always_comb begin
		servo_hit  = (word_q[slcp_pkg::KW_SERVO_LEN] == 8'h00);
		ledon_hit  = (word_q[slcp_pkg::KW_LEDON_LEN] == 8'h00);
		ledoff_hit = (word_q[slcp_pkg::KW_LEDOFF_LEN] == 8'h00);
		for (int i = 0; i < slcp_pkg::KW_SERVO_LEN; i++) begin
			if (word_q[i] != slcp_pkg::KW_SERVO[i]) servo_hit = 1'b0;
		end
		for (int i = 0; i < slcp_pkg::KW_LEDON_LEN; i++) begin
			if (word_q[i] != slcp_pkg::KW_LEDON[i]) ledon_hit = 1'b0;
		end
		for (int i = 0; i < slcp_pkg::KW_LEDOFF_LEN; i++) begin
			if (word_q[i] != slcp_pkg::KW_LEDOFF[i]) ledoff_hit = 1'b0;
		end
	end

	always_comb begin
		if (servo_hit) begin
			cmd = slcp_pkg::CMD_SERVO;
		end else if (ledon_hit) begin
			cmd = slcp_pkg::CMD_LED_ON;
		end else if (ledoff_hit) begin
			cmd = slcp_pkg::CMD_LED_OFF;
		end else begin
			cmd = slcp_pkg::CMD_NONE;
		end
	end

endmodule

// ===== hdl/servo_led_command_parser.sv =====
// Pipeline: an accepted byte goes through the input register, then the result register; a low
// out_ready holds the result register and, through in_ready, the bytes behind it. Throughput:
// one byte per cycle unless out_ready stalls; a byte in the input stage is handled against the
// state left by the byte before it, and span * angle is kept registered ahead of the '.' byte.
// Reset: asynchronous, active low; clears the command word, angle, LED index and LEDs, sets the
// applied servo pulse to 590 and the registers to 590 / 1945 / 2535. No clearing pass.
// Depends on slcp_pkg and slcp_cmd_word.
`timescale 1ns / 1ps

module servo_led_command_parser #(
	parameter int LED_COUNT  = slcp_pkg::LED_COUNT_DEF,
	parameter int WORD_BYTES = slcp_pkg::WORD_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// received bytes
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	// results
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           echo_byte,
	output logic [15:0]          servo_pulse,
	output logic [LED_COUNT-1:0] led_states,
	output logic [1:0]           executed
);

	localparam int PROD_W  = slcp_pkg::PROD_W;
	localparam int QPROD_W = slcp_pkg::PROD_W + slcp_pkg::MAGIC_W;

	// configuration registers
	logic [15:0] zero_q;
	logic [11:0] span_q;
	logic [15:0] limit_q;
	logic        cfg_wr;
	logic [11:0] span_d;

	// pipeline
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	logic [7:0]  echo_s2;
	logic [15:0] pulse_s2;
	logic [LED_COUNT-1:0] led_s2;
	logic [1:0]  exec_s2;
	logic        adv_s2;
	logic        fire;

	// parser state
	logic [7:0]  angle_q;
	logic [7:0]  angle_d;
	logic [3:0]  led_idx_q;
	logic [15:0] pending_q;
	logic [15:0] pending_d;
	logic [15:0] applied_q;
	logic [15:0] applied_d;
	logic [LED_COUNT-1:0] led_q;
	logic [LED_COUNT-1:0] led_d;
	logic [PROD_W-1:0]    prod_q;

	// byte decode
	logic        is_dot;
	logic        is_digit;
	logic [3:0]  digit;
	logic [1:0]  cmd;
	logic        led_cmd;
	slcp_pkg::word_ctl_t wctl;

	// servo arithmetic
	logic [QPROD_W-1:0]          qprod;
	logic [slcp_pkg::QUOT_W-1:0] quot;
	logic [16:0]                 pulse_sum;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q  <= slcp_pkg::ZERO_PULSE_RST;
			span_q  <= slcp_pkg::PULSE_SPAN_RST;
			limit_q <= slcp_pkg::PULSE_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				slcp_pkg::REG_ZERO_PULSE:  zero_q  <= pwdata[15:0];
				slcp_pkg::REG_PULSE_SPAN:  span_q  <= pwdata[11:0];
				slcp_pkg::REG_PULSE_LIMIT: limit_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			slcp_pkg::REG_ZERO_PULSE:  prdata = {16'h0000, zero_q};
			slcp_pkg::REG_PULSE_SPAN:  prdata = {20'h00000, span_q};
			slcp_pkg::REG_PULSE_LIMIT: prdata = {16'h0000, limit_q};
			default:                   prdata = '0;
		endcase
	end

	// next span value, so the product tracks a write in the same cycle
	assign span_d = (cfg_wr && paddr[3:2] == slcp_pkg::REG_PULSE_SPAN) ? pwdata[11:0] : span_q;

	// ---------------- handshake ----------------
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign fire     = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv_s2)   valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	// ---------------- byte decode and command word ----------------
	assign is_dot   = (byte_s1 == slcp_pkg::CH_DOT);
	assign is_digit = (byte_s1 >= slcp_pkg::CH_ZERO) && (byte_s1 <= slcp_pkg::CH_NINE);
	assign digit    = 4'(byte_s1 - slcp_pkg::CH_ZERO);

	assign wctl.exec  = fire && is_dot;
	assign wctl.store = fire && !is_dot && !is_digit;

	slcp_cmd_word #(
		.WORD_BYTES(WORD_BYTES)
	) u_word (
		.clk    (clk),
		.arst_n (arst_n),
		.wctl   (wctl),
		.data   (byte_s1),
		.cmd    (cmd)
	);

	assign led_cmd = (cmd == slcp_pkg::CMD_LED_ON) || (cmd == slcp_pkg::CMD_LED_OFF);

	// ---------------- servo path ----------------
	always_comb begin
		angle_d = angle_q;
		if (fire && cmd == slcp_pkg::CMD_SERVO) begin
			if (is_dot) begin
				angle_d = '0;
			end else if (is_digit) begin
				// angle * 10 + digit, wrapping at 8 bits
				angle_d = 8'(11'({angle_q, 3'b000}) + 11'({angle_q, 1'b0}) + 11'(digit));
			end
		end
	end

	// floor(span * angle / 180) by reciprocal multiply on the registered product
	assign qprod     = QPROD_W'(prod_q) * QPROD_W'(slcp_pkg::DIV_MAGIC);
	assign quot      = qprod[slcp_pkg::DIV_SHIFT +: slcp_pkg::QUOT_W];
	assign pulse_sum = 17'(zero_q) + 17'(quot);

	always_comb begin
		pending_d = pending_q;
		if (fire && is_dot && cmd == slcp_pkg::CMD_SERVO) begin
			pending_d = pulse_sum[16] ? 16'hFFFF : pulse_sum[15:0];
		end
		applied_d = applied_q;
		if (fire && pending_d <= limit_q) begin
			applied_d = pending_d;
		end
	end

	// ---------------- LED path ----------------
	always_comb begin
		led_d = led_q;
		if (fire && is_dot && led_cmd) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				if (led_idx_q == 4'(i)) begin
					led_d[i] = (cmd == slcp_pkg::CMD_LED_ON);
				end
			end
		end
	end

	// ---------------- state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q   <= '0;
			led_idx_q <= '0;
			pending_q <= slcp_pkg::ZERO_PULSE_RST;
			applied_q <= slcp_pkg::ZERO_PULSE_RST;
			led_q     <= '0;
			prod_q    <= '0;
		end else begin
			angle_q   <= angle_d;
			pending_q <= pending_d;
			applied_q <= applied_d;
			led_q     <= led_d;
			prod_q    <= PROD_W'(span_d) * PROD_W'(angle_d);
			if (fire && is_digit && led_cmd) begin
				led_idx_q <= digit;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk) begin
		if (fire) begin
			echo_s2  <= byte_s1;
			pulse_s2 <= applied_d;
			led_s2   <= led_d;
			exec_s2  <= is_dot ? cmd : slcp_pkg::CMD_NONE;
		end
	end

	assign out_valid   = valid_s2;
	assign echo_byte   = echo_s2;
	assign servo_pulse = pulse_s2;
	assign led_states  = led_s2;
	assign executed    = exec_s2;

endmodule

// ===== verif/servo_led_command_parser_tb.sv =====
// Self-checking testbench for servo_led_command_parser: byte stream in, echo plus servo/LED
// status out, configuration over the APB port. Predicts every result in-house and compares it.
// Depends on slcp_pkg and the parser RTL.
`timescale 1ns / 1ps

module servo_led_command_parser_tb;

	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	typedef struct packed {
		logic [7:0]                         echo;
		logic [15:0]                        pulse;
		logic [slcp_pkg::LED_COUNT_DEF-1:0] leds;
		logic [1:0]                         cmd;
	} parser_out_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               psel = 1'b0;
	logic                               penable = 1'b0;
	logic                               pwrite = 1'b0;
	logic [3:0]                         paddr = '0;
	logic [31:0]                        pwdata = '0;
	logic [31:0]                        prdata;
	logic                               pready;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [7:0]                         rx_byte = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [7:0]                         echo_byte;
	logic [15:0]                        servo_pulse;
	logic [slcp_pkg::LED_COUNT_DEF-1:0] led_states;
	logic [1:0]                         executed;

	// parser state as predicted
	logic [7:0]                         cmd_word [slcp_pkg::WORD_BYTES_DEF] = '{default: 8'h00};
	int unsigned                        cmd_len = 0;
	logic [7:0]                         angle_val = '0;
	logic [3:0]                         led_sel = '0;
	logic [15:0]                        staged_pulse = slcp_pkg::ZERO_PULSE_RST;
	logic [15:0]                        live_pulse = slcp_pkg::ZERO_PULSE_RST;
	logic [slcp_pkg::LED_COUNT_DEF-1:0] led_mask = '0;
	logic [15:0]                        cfg_zero = slcp_pkg::ZERO_PULSE_RST;
	logic [11:0]                        cfg_span = slcp_pkg::PULSE_SPAN_RST;
	logic [15:0]                        cfg_limit = slcp_pkg::PULSE_LIMIT_RST;

	parser_out_t reply_q [$];
	int          mismatches = 0;
	int          bytes_sent = 0;
	int          stall_left = 0;
	bit          gaps_on = 1'b1;

	servo_led_command_parser u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.echo_byte  (echo_byte),
		.servo_pulse(servo_pulse),
		.led_states (led_states),
		.executed   (executed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// the word matches only when it ends (zero byte) right after the keyword
	function automatic logic [1:0] decode_word();
		logic hit_servo, hit_on, hit_off;
		hit_servo = (cmd_word[slcp_pkg::KW_SERVO_LEN] == 8'h00);
		hit_on    = (cmd_word[slcp_pkg::KW_LEDON_LEN] == 8'h00);
		hit_off   = (cmd_word[slcp_pkg::KW_LEDOFF_LEN] == 8'h00);
		for (int i = 0; i < slcp_pkg::KW_SERVO_LEN; i++)
			if (cmd_word[i] != slcp_pkg::KW_SERVO[i]) hit_servo = 1'b0;
		for (int i = 0; i < slcp_pkg::KW_LEDON_LEN; i++)
			if (cmd_word[i] != slcp_pkg::KW_LEDON[i]) hit_on = 1'b0;
		for (int i = 0; i < slcp_pkg::KW_LEDOFF_LEN; i++)
			if (cmd_word[i] != slcp_pkg::KW_LEDOFF[i]) hit_off = 1'b0;
		if (hit_servo)
			return slcp_pkg::CMD_SERVO;
		if (hit_on)
			return slcp_pkg::CMD_LED_ON;
		if (hit_off)
			return slcp_pkg::CMD_LED_OFF;
		return slcp_pkg::CMD_NONE;
	endfunction

	function automatic parser_out_t parse_byte(input logic [7:0] b);
		logic [1:0]  cmd;
		logic [1:0]  done;
		logic        led_cmd;
		int unsigned scaled;
		cmd     = decode_word();
		done    = slcp_pkg::CMD_NONE;
		led_cmd = (cmd == slcp_pkg::CMD_LED_ON) || (cmd == slcp_pkg::CMD_LED_OFF);
		if (b == slcp_pkg::CH_DOT) begin
			done = cmd;
			if (cmd == slcp_pkg::CMD_SERVO) begin
				scaled = 32'(cfg_zero) + (32'(cfg_span) * 32'(angle_val)) / 180;
				staged_pulse = (scaled > 65535) ? 16'hFFFF : scaled[15:0];
				angle_val = '0;
			end else if (led_cmd && led_sel < slcp_pkg::LED_COUNT_DEF) begin
				led_mask[led_sel] = (cmd == slcp_pkg::CMD_LED_ON);
			end
			cmd_len = 0;
			cmd_word[slcp_pkg::EXEC_CLEAR_BYTE] = 8'h00;
		end else if (b >= slcp_pkg::CH_ZERO && b <= slcp_pkg::CH_NINE) begin
			if (cmd == slcp_pkg::CMD_SERVO)
				angle_val = 8'(angle_val * 8'd10 + (b - slcp_pkg::CH_ZERO));
			else if (led_cmd)
				led_sel = 4'(b - slcp_pkg::CH_ZERO);
		end else if (cmd_len < slcp_pkg::WORD_BYTES_DEF) begin
			cmd_word[cmd_len] = b;
			cmd_len++;
		end
		if (staged_pulse <= cfg_limit)
			live_pulse = staged_pulse;
		return '{echo: b, pulse: live_pulse, leds: led_mask, cmd: done};
	endfunction

	always @(posedge clk) begin
		if (!gaps_on || stall_left == 0) begin
			out_ready <= 1'b1;
			stall_left = pick_gap();
		end else begin
			out_ready <= 1'b0;
			stall_left--;
		end
	end

	// predict on input transactions first, then check output transactions
	always @(posedge clk) begin : scoreboard
		parser_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				reply_q.push_back(parse_byte(rx_byte));
			if (out_valid && out_ready) begin
				if (reply_q.size() == 0) begin
					$display("%t: unexpected result echo_byte %h", $time, echo_byte);
					mismatches++;
				end else begin
					want = reply_q.pop_front();
					if (echo_byte !== want.echo) begin
						$display("%t: echo_byte expected %h got %h", $time, want.echo, echo_byte);
						mismatches++;
					end
					if (servo_pulse !== want.pulse) begin
						$display("%t: servo_pulse expected %0d got %0d", $time, want.pulse,
							servo_pulse);
						mismatches++;
					end
					if (led_states !== want.leds) begin
						$display("%t: led_states expected %b got %b", $time, want.leds, led_states);
						mismatches++;
					end
					if (executed !== want.cmd) begin
						$display("%t: executed expected %0d got %0d", $time, want.cmd, executed);
						mismatches++;
					end
				end
			end
		end
	end

	// called just after a rising edge; returns at the edge that accepts the byte
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// step one edge first so the last accepted transaction is already queued
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			slcp_pkg::REG_ZERO_PULSE:  cfg_zero  = data[15:0];
			slcp_pkg::REG_PULSE_SPAN:  cfg_span  = data[11:0];
			slcp_pkg::REG_PULSE_LIMIT: cfg_limit = data[15:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_check(input logic [1:0] idx);
		logic [31:0] want;
		case (idx)
			slcp_pkg::REG_ZERO_PULSE: want = 32'(cfg_zero);
			slcp_pkg::REG_PULSE_SPAN: want = 32'(cfg_span);
			default:                  want = 32'(cfg_limit);
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== want) begin
			$display("%t: register %0d read expected %h got %h", $time, idx, want, prdata);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// upper bits of each write carry noise that the register must drop
	task automatic program_servo(input logic [15:0] zero, input logic [11:0] span,
		input logic [15:0] limit);
		wait_drained();
		cfg_write(slcp_pkg::REG_ZERO_PULSE, {16'($urandom()), zero});
		cfg_write(slcp_pkg::REG_PULSE_SPAN, {20'($urandom()), span});
		cfg_write(slcp_pkg::REG_PULSE_LIMIT, {16'($urandom()), limit});
		cfg_check(slcp_pkg::REG_ZERO_PULSE);
		cfg_check(slcp_pkg::REG_PULSE_SPAN);
		cfg_check(slcp_pkg::REG_PULSE_LIMIT);
	endtask

	// mostly well-formed commands with random arguments, the rest noise and broken words
	task automatic send_sentence();
		int         kind, ndig;
		logic [1:0] pick;
		kind = $urandom_range(0, 99);
		if (kind < 80) begin
			pick = 2'($urandom_range(slcp_pkg::CMD_SERVO, slcp_pkg::CMD_LED_OFF));
			case (pick)
				slcp_pkg::CMD_SERVO:  send_text("servo,");
				slcp_pkg::CMD_LED_ON: send_text("ledon,");
				default:              send_text("ledoff,");
			endcase
			if ($urandom_range(0, 99) < 8)
				send_byte(8'($urandom_range(8'h61, 8'h7A)));
			do begin
				ndig = (pick == slcp_pkg::CMD_SERVO) ? $urandom_range(0, 4) : $urandom_range(0, 2);
				for (int i = 0; i < ndig; i++) begin
					if (pick != slcp_pkg::CMD_SERVO && $urandom_range(0, 99) < 70)
						send_byte(8'(slcp_pkg::CH_ZERO
							+ $urandom_range(0, slcp_pkg::LED_COUNT_DEF - 1)));
					else
						send_byte(8'(slcp_pkg::CH_ZERO + $urandom_range(0, 9)));
				end
				send_byte(slcp_pkg::CH_DOT);
			end while ($urandom_range(0, 99) < 15);
		end else begin
			ndig = $urandom_range(1, 12);
			for (int i = 0; i < ndig; i++)
				send_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1) == 1)
				send_byte(slcp_pkg::CH_DOT);
		end
	endtask

	task automatic run_traffic(input int count);
		int stop_at;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at)
			send_sentence();
	endtask

	task automatic test_register_reset();
		cfg_check(slcp_pkg::REG_ZERO_PULSE);
		cfg_check(slcp_pkg::REG_PULSE_SPAN);
		cfg_check(slcp_pkg::REG_PULSE_LIMIT);
	endtask

	// angle wrap, LED on, LED off with an index out of range, a zero byte opening a new word,
	// all-ones byte, and an execute with no command
	task automatic test_directed();
		send_text("servo,300.");
		send_text("ledon,2.");
		send_text("ledoff,9.");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(slcp_pkg::CH_DOT);
	endtask

	task automatic test_default_traffic();
		run_traffic(400);
	endtask

	task automatic test_floor_settings();
		program_servo(16'd0, 12'd0, 16'd0);
		run_traffic(200);
	endtask

	// saturation on every servo command with a nonzero angle; no idling on either side
	task automatic test_ceiling_settings();
		program_servo(16'hFFFF, 12'hFFF, 16'hFFFF);
		gaps_on = 1'b0;
		run_traffic(200);
		wait_drained();
		gaps_on = 1'b1;
	endtask

	// sums straddle both the limit and the saturation point
	task automatic test_limit_window();
		program_servo(16'd60000, 12'hFFF, 16'd62000);
		run_traffic(250);
	endtask

	task automatic test_random_settings();
		int zero, span, limit;
		for (int round = 0; round < 3; round++) begin
			zero  = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3000) : $urandom_range(0, 65535);
			span  = $urandom_range(0, 4095);
			limit = ($urandom_range(0, 3) != 0) ? zero + $urandom_range(0, 4500)
				: $urandom_range(0, 65535);
			if (limit > 65535)
				limit = 65535;
			program_servo(16'(zero), 12'(span), 16'(limit));
			if (round == 0) begin
				// a write to an unmapped address must leave all registers alone
				cfg_write(REG_UNMAPPED, $urandom());
				test_register_reset();
			end
			run_traffic(250);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed();
		test_default_traffic();
		test_floor_settings();
		test_ceiling_settings();
		test_limit_window();
		test_random_settings();
		wait_drained();
		if (mismatches == 0)
			$display("[servo_led_command_parser] OK");
		else
			$display("[servo_led_command_parser] ERROR");
		$finish;
	end

	initial begin
		#25_000_000;
		$display("[servo_led_command_parser] ERROR");
		$finish;
	end

endmodule
